// File: design/rti_pkg.sv
// Shared widths, types, register indexes and helpers for the ray-triangle intersection unit.
package rti_pkg;

  localparam int COORD_WIDTH = 21;
  localparam int FRAC_BITS   = 12;

  localparam int CW   = COORD_WIDTH;
  localparam int NW   = 3 * CW;           // packed xyz vector
  localparam int DW   = CW - 1;           // distance / max_distance width
  localparam int UW   = FRAC_BITS + 1;    // barycentric width
  localparam int EW   = CW + 1;           // edge and origin offset width
  localparam int PRW  = 2 * EW;           // cross product term width
  localparam int CRW  = PRW + 1;          // cross product width
  localparam int SPL  = EW;               // low split of a cross component
  localparam int HIW  = CRW - SPL;        // high split of a cross component
  localparam int PPW  = EW + HIW;         // partial product width
  localparam int DOTW = EW + CRW + 2;     // dot product width
  localparam int RW   = DOTW + DW + 1;    // divider remainder width
  localparam int HPW  = DW + 1 + CW;      // t times direction
  localparam int SW   = HPW - FRAC_BITS + 1;

  localparam int IN_TDATA_W  = ((6 * CW + DW + 7) / 8) * 8;
  localparam int OUT_FIELD_W = DW + 2 * UW + NW + NW;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int IDXW        = 3;

  localparam logic [IDXW-1:0] REG_VERTEX_A     = IDXW'(0);
  localparam logic [IDXW-1:0] REG_VERTEX_B     = IDXW'(1);
  localparam logic [IDXW-1:0] REG_VERTEX_C     = IDXW'(2);
  localparam logic [IDXW-1:0] REG_UNIT_NORMAL  = IDXW'(3);
  localparam logic [IDXW-1:0] REG_MIN_DISTANCE = IDXW'(4);

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [EW-1:0]   edge_t;
  typedef logic signed [PRW-1:0]  prod_t;
  typedef logic signed [CRW-1:0]  cross_t;
  typedef logic signed [PPW-1:0]  part_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [HPW-1:0]  hp_t;
  typedef logic signed [SW-1:0]   sw_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic [DW-1:0]          dist_t;
  typedef logic [UW-1:0]          bary_t;
  typedef logic [NW-1:0]          vec_t;

  typedef struct packed {
    logic  valid;
    logic  miss;
    rem_t  det;
    rem_t  rt;
    rem_t  ru;
    rem_t  rv;
    vec_t  o;
    vec_t  d;
    dist_t maxd;
  } front_t;

  typedef struct packed {
    logic  valid;
    logic  miss;
    rem_t  det;
    rem_t  rt;
    rem_t  ru;
    rem_t  rv;
    dist_t qt;
    bary_t qu;
    bary_t qv;
    vec_t  o;
    vec_t  d;
    dist_t maxd;
  } dstage_t;

  typedef struct packed {
    logic  valid;
    logic  miss;
    logic  remz;
    dist_t tq;
    bary_t bu;
    bary_t bv;
    vec_t  o;
    vec_t  d;
    dist_t maxd;
  } div_t;

  function automatic int nxt(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  function automatic coord_t comp(input vec_t p, input int k);
    return p[k*CW +: CW];
  endfunction

endpackage

// File: design/rti_front.sv
// Edges, cross products, split dot products, sign normalization and range checks.
module rti_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rti_pkg::vec_t      ray_o,
  input  rti_pkg::vec_t      ray_d,
  input  rti_pkg::dist_t     ray_maxd,
  input  rti_pkg::vec_t      vtx_a,
  input  rti_pkg::vec_t      vtx_b,
  input  rti_pkg::vec_t      vtx_c,
  output rti_pkg::front_t    fout
);
  import rti_pkg::*;

  logic v1, v2, v3, v4, v5, v6;

  edge_t  s1_e1 [3];
  edge_t  s1_e2 [3];
  edge_t  s1_tv [3];
  vec_t   s1_o, s1_d;
  dist_t  s1_maxd;

  prod_t  s2_pp [3];
  prod_t  s2_pm [3];
  prod_t  s2_qp [3];
  prod_t  s2_qm [3];
  edge_t  s2_e1 [3];
  edge_t  s2_e2 [3];
  edge_t  s2_tv [3];
  vec_t   s2_o, s2_d;
  dist_t  s2_maxd;

  cross_t s3_pv [3];
  cross_t s3_qv [3];
  edge_t  s3_e1 [3];
  edge_t  s3_e2 [3];
  edge_t  s3_tv [3];
  vec_t   s3_o, s3_d;
  dist_t  s3_maxd;

  // dot order: det, nu, nv, nt
  part_t  s4_ph [4][3];
  part_t  s4_pl [4][3];
  vec_t   s4_o, s4_d;
  dist_t  s4_maxd;

  dot_t   s5_dot [4];
  vec_t   s5_o, s5_d;
  dist_t  s5_maxd;

  dot_t   s6_det, s6_nu, s6_nv, s6_nt;
  logic   s6_zero;
  vec_t   s6_o, s6_d;
  dist_t  s6_maxd;

  edge_t  lft [4][3];
  cross_t rgt [4][3];
  dot_t   nsum;
  rem_t   tt, dsh;
  logic   uv_bad, tneg, tovf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lft[0][k] = s3_e1[k];
      lft[1][k] = s3_tv[k];
      lft[2][k] = edge_t'(comp(s3_d, k));
      lft[3][k] = s3_e2[k];
      rgt[0][k] = s3_pv[k];
      rgt[1][k] = s3_pv[k];
      rgt[2][k] = s3_qv[k];
      rgt[3][k] = s3_qv[k];
    end
  end

  always_comb begin
    nsum   = s6_nu + s6_nv;
    tt     = rem_t'(s6_nt) << FRAC_BITS;
    dsh    = rem_t'(s6_det) << DW;
    tneg   = s6_nt[DOTW-1];
    tovf   = tt >= dsh;
    uv_bad = s6_nu[DOTW-1] || s6_nv[DOTW-1] || (s6_nu > s6_det) || (nsum > s6_det);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      fout.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      fout.valid <= v6;

      // edges and origin offset
      for (int k = 0; k < 3; k++) begin
        s1_e1[k] <= edge_t'(comp(vtx_b, k)) - edge_t'(comp(vtx_a, k));
        s1_e2[k] <= edge_t'(comp(vtx_c, k)) - edge_t'(comp(vtx_a, k));
        s1_tv[k] <= edge_t'(comp(ray_o, k)) - edge_t'(comp(vtx_a, k));
      end
      s1_o    <= ray_o;
      s1_d    <= ray_d;
      s1_maxd <= ray_maxd;

      // cross product terms: p = d x e2, q = tv x e1
      for (int k = 0; k < 3; k++) begin
        s2_pp[k] <= prod_t'(comp(s1_d, nxt(k))) * prod_t'(s1_e2[nxt(nxt(k))]);
        s2_pm[k] <= prod_t'(comp(s1_d, nxt(nxt(k)))) * prod_t'(s1_e2[nxt(k)]);
        s2_qp[k] <= prod_t'(s1_tv[nxt(k)]) * prod_t'(s1_e1[nxt(nxt(k))]);
        s2_qm[k] <= prod_t'(s1_tv[nxt(nxt(k))]) * prod_t'(s1_e1[nxt(k)]);
        s2_e1[k] <= s1_e1[k];
        s2_e2[k] <= s1_e2[k];
        s2_tv[k] <= s1_tv[k];
      end
      s2_o    <= s1_o;
      s2_d    <= s1_d;
      s2_maxd <= s1_maxd;

      for (int k = 0; k < 3; k++) begin
        s3_pv[k] <= cross_t'(s2_pp[k]) - cross_t'(s2_pm[k]);
        s3_qv[k] <= cross_t'(s2_qp[k]) - cross_t'(s2_qm[k]);
        s3_e1[k] <= s2_e1[k];
        s3_e2[k] <= s2_e2[k];
        s3_tv[k] <= s2_tv[k];
      end
      s3_o    <= s2_o;
      s3_d    <= s2_d;
      s3_maxd <= s2_maxd;

      // split each cross component into a signed high and an unsigned low half
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          s4_ph[j][k] <= part_t'(lft[j][k]) * part_t'($signed(rgt[j][k][CRW-1:SPL]));
          s4_pl[j][k] <= part_t'(lft[j][k]) * part_t'($signed({1'b0, rgt[j][k][SPL-1:0]}));
        end
      end
      s4_o    <= s3_o;
      s4_d    <= s3_d;
      s4_maxd <= s3_maxd;

      for (int j = 0; j < 4; j++) begin
        s5_dot[j] <= (dot_t'(s4_ph[j][0]) <<< SPL) + dot_t'(s4_pl[j][0])
                   + (dot_t'(s4_ph[j][1]) <<< SPL) + dot_t'(s4_pl[j][1])
                   + (dot_t'(s4_ph[j][2]) <<< SPL) + dot_t'(s4_pl[j][2]);
      end
      s5_o    <= s4_o;
      s5_d    <= s4_d;
      s5_maxd <= s4_maxd;

      // flip all signs when det is negative so that det comes out non-negative
      s6_zero <= (s5_dot[0] == '0);
      s6_det  <= s5_dot[0][DOTW-1] ? -s5_dot[0] : s5_dot[0];
      s6_nu   <= s5_dot[0][DOTW-1] ? -s5_dot[1] : s5_dot[1];
      s6_nv   <= s5_dot[0][DOTW-1] ? -s5_dot[2] : s5_dot[2];
      s6_nt   <= s5_dot[0][DOTW-1] ? -s5_dot[3] : s5_dot[3];
      s6_o    <= s5_o;
      s6_d    <= s5_d;
      s6_maxd <= s5_maxd;

      fout.miss <= s6_zero || uv_bad || tneg || tovf;
      fout.det  <= rem_t'(s6_det);
      fout.rt   <= tt;
      fout.ru   <= rem_t'(s6_nu) << FRAC_BITS;
      fout.rv   <= rem_t'(s6_nv) << FRAC_BITS;
      fout.o    <= s6_o;
      fout.d    <= s6_d;
      fout.maxd <= s6_maxd;
    end
  end

endmodule

// File: design/rti_divider.sv
// Restoring divider pipeline, one quotient bit per stage for t; u and v get theirs in the last UW stages.
module rti_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rti_pkg::front_t fin,
  output rti_pkg::div_t   dout
);
  import rti_pkg::*;

  dstage_t st [DW+1];

  always_comb begin
    st[0].valid = fin.valid;
    st[0].miss  = fin.miss;
    st[0].det   = fin.det;
    st[0].rt    = fin.rt;
    st[0].ru    = fin.ru;
    st[0].rv    = fin.rv;
    st[0].qt    = '0;
    st[0].qu    = '0;
    st[0].qv    = '0;
    st[0].o     = fin.o;
    st[0].d     = fin.d;
    st[0].maxd  = fin.maxd;
  end

  for (genvar g = 0; g < DW; g++) begin : g_step
    localparam int SH = DW - 1 - g;
    dstage_t nx;
    rem_t    cmp;

    always_comb begin
      nx  = st[g];
      cmp = st[g].det << SH;
      if (st[g].rt >= cmp) begin
        nx.rt = st[g].rt - cmp;
        nx.qt = st[g].qt | (dist_t'(1) << SH);
      end
      if (SH < UW) begin
        if (st[g].ru >= cmp) begin
          nx.ru = st[g].ru - cmp;
          nx.qu = st[g].qu | (bary_t'(1) << SH);
        end
        if (st[g].rv >= cmp) begin
          nx.rv = st[g].rv - cmp;
          nx.qv = st[g].qv | (bary_t'(1) << SH);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[g+1].valid <= 1'b0;
      end else if (en) begin
        st[g+1] <= nx;
      end
    end
  end

  always_comb begin
    dout.valid = st[DW].valid;
    dout.miss  = st[DW].miss;
    dout.remz  = (st[DW].rt == '0);
    dout.tq    = st[DW].qt;
    dout.bu    = st[DW].qu;
    dout.bv    = st[DW].qv;
    dout.o     = st[DW].o;
    dout.d     = st[DW].d;
    dout.maxd  = st[DW].maxd;
  end

endmodule

// File: design/rti_finish.sv
// Distance range test, hit point with saturation and the output register.
module rti_finish (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rti_pkg::div_t  din,
  input  rti_pkg::dist_t min_d,
  input  rti_pkg::vec_t  normal,
  output logic           out_valid,
  output logic           out_hit,
  output rti_pkg::dist_t out_dist,
  output rti_pkg::bary_t out_u,
  output rti_pkg::bary_t out_v,
  output rti_pkg::vec_t  out_point,
  output rti_pkg::vec_t  out_normal
);
  import rti_pkg::*;

  localparam sw_t CMAX = sw_t'((2 ** (CW - 1)) - 1);
  localparam sw_t CMIN = -CMAX - sw_t'(1);

  logic  f1_valid, f1_hit;
  dist_t f1_q;
  bary_t f1_u, f1_v;
  hp_t   f1_pr [3];
  vec_t  f1_o;
  logic  hit;
  sw_t   psum [3];
  vec_t  pnt;

  assign hit = !din.miss && (din.tq >= min_d)
            && ((din.tq < din.maxd) || ((din.tq == din.maxd) && din.remz));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = sw_t'(comp(f1_o, k)) + sw_t'(f1_pr[k] >>> FRAC_BITS);
      if (psum[k] > CMAX) begin
        pnt[k*CW +: CW] = CMAX[CW-1:0];
      end else if (psum[k] < CMIN) begin
        pnt[k*CW +: CW] = CMIN[CW-1:0];
      end else begin
        pnt[k*CW +: CW] = psum[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= din.valid;
      f1_hit   <= hit;
      f1_q     <= din.tq;
      f1_u     <= din.bu;
      f1_v     <= din.bv;
      f1_o     <= din.o;
      for (int k = 0; k < 3; k++) begin
        f1_pr[k] <= hp_t'($signed({1'b0, din.tq})) * hp_t'(comp(din.d, k));
      end

      // zero every payload field on a miss
      out_valid  <= f1_valid;
      out_hit    <= f1_hit;
      out_dist   <= f1_hit ? f1_q : '0;
      out_u      <= f1_hit ? f1_u : '0;
      out_v      <= f1_hit ? f1_v : '0;
      out_point  <= f1_hit ? pnt : '0;
      out_normal <= f1_hit ? normal : '0;
    end
  end

endmodule

// File: design/ray_triangle_intersect_unit.sv
// Top level of the ray-triangle intersection unit: ports, configuration and pipeline.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  ray in   | in        | s_tvalid/s_tready  | s_tdata: origin xyz, dir xyz, max_distance
//  result   | out       | m_tvalid/m_tready  | m_tuser: hit; m_tdata: t, u, v, point, normal
//  config   | in        | cfg_we             | cfg_index, cfg_data
//
// One ray per cycle unless the pipeline holds. The pipeline has 7 geometry stages, 20 divider
// stages (one quotient bit each) and 2 finishing stages including the output register.
// Reset clears all valid bits and loads the register defaults (min_distance = 1).
// The whole pipeline holds while a result waits on m_tready; s_tready follows.
module ray_triangle_intersect_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, zero pad
  input  logic [rti_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // distance, bary_u, bary_v, point_x, point_y, point_z, normal_out, zero pad
  output logic [rti_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // hit
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [rti_pkg::IDXW-1:0]         cfg_index,
  input  logic [rti_pkg::NW-1:0]           cfg_data
);
  import rti_pkg::*;

  vec_t   vtx_a, vtx_b, vtx_c, unit_normal;
  dist_t  min_distance;
  logic   en;
  front_t fr;
  div_t   dv;
  logic   out_hit;
  dist_t  out_dist;
  bary_t  out_u, out_v;
  vec_t   out_point, out_normal;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_a        <= '0;
      vtx_b        <= '0;
      vtx_c        <= '0;
      unit_normal  <= '0;
      min_distance <= dist_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A:     vtx_a        <= cfg_data;
        REG_VERTEX_B:     vtx_b        <= cfg_data;
        REG_VERTEX_C:     vtx_c        <= cfg_data;
        REG_UNIT_NORMAL:  unit_normal  <= cfg_data;
        REG_MIN_DISTANCE: min_distance <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  rti_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .ray_o    (s_tdata[NW-1:0]),
    .ray_d    (s_tdata[2*NW-1:NW]),
    .ray_maxd (s_tdata[2*NW+DW-1:2*NW]),
    .vtx_a    (vtx_a),
    .vtx_b    (vtx_b),
    .vtx_c    (vtx_c),
    .fout     (fr)
  );

  rti_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .fin  (fr),
    .dout (dv)
  );

  rti_finish u_fin (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .din        (dv),
    .min_d      (min_distance),
    .normal     (unit_normal),
    .out_valid  (m_tvalid),
    .out_hit    (out_hit),
    .out_dist   (out_dist),
    .out_u      (out_u),
    .out_v      (out_v),
    .out_point  (out_point),
    .out_normal (out_normal)
  );

  assign m_tuser = out_hit;
  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                    out_normal, out_point, out_v, out_u, out_dist};

endmodule
